/* rtl/kvtl_pkg.sv */
// shared types and codes for the keyframe vector track block
package kvtl_pkg;

    typedef logic signed [31:0] fix_t;
    typedef fix_t [2:0] vec_t;

    typedef struct packed {
        logic [31:0] stamp;
        vec_t        vec;
    } key_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    localparam int MAX_KEYS_DEFAULT = 64;

    localparam logic [15:0] EPSILON_RESET = 16'd66;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] STATUS_HIT   = 2'd0;
    localparam logic [1:0] STATUS_LERP  = 2'd1;
    localparam logic [1:0] STATUS_HOLD  = 2'd2;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

    localparam logic [1:0] COMP_LAST = 2'd2;

    localparam int ALPHA_W = 17;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 17'h10000;

endpackage

/* rtl/keyframe_vector_track_lerp.sv */
// Keyframe vector track with fixed-point linear interpolation. Clear and append
// transactions are done in the cycle that accepts them. A query on an empty track goes
// straight to the emit state. Otherwise the key scan reads one key per cycle from the key
// memory, and an exact hit or a held last key is then read back from the key memory and
// loaded. An interpolating query passes the scan, the bit-serial alpha divider, two key
// reads and a load, and the three-component multiply pipe. A result that cannot enter a
// full output register waits in the emit state. The block takes no new transaction while
// a query is in flight; a finished result waits in the output register while the next
// one is taken.
module keyframe_vector_track_lerp
    import kvtl_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        epsilon_we,
    input  logic [15:0] epsilon_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] key_time,
    input  fix_t        key_x,
    input  fix_t        key_y,
    input  fix_t        key_z,
    input  logic [31:0] query_time,
    output logic        out_valid,
    input  logic        out_ready,
    output fix_t        out_x,
    output fix_t        out_y,
    output fix_t        out_z,
    output logic [1:0]  status
);

    localparam int IW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam logic [CW-1:0] KEYS_MAX = CW'(MAX_KEYS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SCAN  = 10'b0000000010,
        S_DIV   = 10'b0000000100,
        S_RD_A  = 10'b0000001000,
        S_RD_B  = 10'b0000010000,
        S_LD_B  = 10'b0000100000,
        S_LERP  = 10'b0001000000,
        S_FETCH = 10'b0010000000,
        S_LOAD  = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [15:0]        eps_reg;
    logic               out_valid_reg, out_valid_next;
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IW-1:0]      chk_idx_reg, chk_idx_next;
    logic [IW-1:0]      prev_idx_reg, prev_idx_next;
    logic [IW-1:0]      cur_idx_reg, cur_idx_next;
    logic [IW-1:0]      sel_idx_reg, sel_idx_next;
    logic [31:0]        prev_time_reg, prev_time_next;
    logic [31:0]        q_reg, q_next;
    vec_t               a_vec_reg, a_vec_next;
    vec_t               b_vec_reg, b_vec_next;
    vec_t               res_vec_reg, res_vec_next;
    logic [1:0]         res_status_reg, res_status_next;
    vec_t               out_vec_reg, out_vec_next;
    logic [1:0]         out_status_reg, out_status_next;

    logic               wr_en;
    key_t               wr_key;
    logic [IW-1:0]      rd_addr;
    key_t               rd_key;

    logic [31:0]        t_cur, t_prev, t_gap, span;
    logic               hit, bracket, last_key;
    logic               div_start;
    div_status_t        div_stat;
    logic [ALPHA_W-1:0] alpha;
    logic               lerp_start, lerp_done;
    vec_t               lerp_res;

    assign wr_key.stamp = key_time;
    assign wr_key.vec   = {key_z, key_y, key_x};

    kvtl_key_store #(
        .MAX_KEYS (MAX_KEYS),
        .IW       (IW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IW-1:0]),
        .wr_key  (wr_key),
        .rd_addr (rd_addr),
        .rd_key  (rd_key)
    );

    // scan compare on the key read in the previous cycle
    assign t_cur    = rd_key.stamp;
    assign t_prev   = (chk_idx_reg == '0) ? t_cur : prev_time_reg;
    assign t_gap    = (t_cur >= q_reg) ? (t_cur - q_reg) : (q_reg - t_cur);
    assign hit      = (t_gap <= {16'd0, eps_reg});
    assign bracket  = (t_prev <= q_reg) && (t_cur >= q_reg);
    assign span     = t_cur - t_prev;
    assign last_key = (CW'(chk_idx_reg) == count_reg - CW'(1));

    kvtl_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (q_reg - t_prev),
        .den   (span),
        .stat  (div_stat),
        .quot  (alpha)
    );

    kvtl_lerp u_lerp (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (lerp_start),
        .alpha   (alpha),
        .a_vec   (a_vec_reg),
        .b_vec   (b_vec_reg),
        .done    (lerp_done),
        .res_vec (lerp_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        rd_idx_next     = rd_idx_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        prev_idx_next   = prev_idx_reg;
        cur_idx_next    = cur_idx_reg;
        sel_idx_next    = sel_idx_reg;
        prev_time_next  = prev_time_reg;
        q_next          = q_reg;
        a_vec_next      = a_vec_reg;
        b_vec_next      = b_vec_reg;
        res_vec_next    = res_vec_reg;
        res_status_next = res_status_reg;
        out_vec_next    = out_vec_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        rd_addr         = sel_idx_reg;
        div_start       = 1'b0;
        lerp_start      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg < KEYS_MAX)
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_QUERY:
                        begin
                            q_next        = query_time;
                            rd_idx_next   = '0;
                            chk_vld_next  = 1'b0;
                            prev_idx_next = '0;
                            if (count_reg == '0)
                            begin
                                res_vec_next    = '0;
                                res_status_next = STATUS_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                rd_addr      = rd_idx_reg[IW-1:0];
                chk_vld_next = (rd_idx_reg < count_reg);
                chk_idx_next = rd_idx_reg[IW-1:0];
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (chk_vld_reg)
                begin
                    if (hit)
                    begin
                        sel_idx_next    = chk_idx_reg;
                        res_status_next = STATUS_HIT;
                        state_next      = S_FETCH;
                    end
                    else if (bracket)
                    begin
                        if (span == '0)
                        begin
                            sel_idx_next    = prev_idx_reg;
                            res_status_next = STATUS_LERP;
                            state_next      = S_FETCH;
                        end
                        else
                        begin
                            div_start    = 1'b1;
                            cur_idx_next = chk_idx_reg;
                            state_next   = S_DIV;
                        end
                    end
                    else
                    begin
                        prev_idx_next  = chk_idx_reg;
                        prev_time_next = t_cur;
                        if (last_key)
                        begin
                            sel_idx_next    = chk_idx_reg;
                            res_status_next = STATUS_HOLD;
                            state_next      = S_FETCH;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_RD_A;
                end
            end
            S_RD_A:
            begin
                rd_addr    = prev_idx_reg;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                rd_addr    = cur_idx_reg;
                a_vec_next = rd_key.vec;
                state_next = S_LD_B;
            end
            S_LD_B:
            begin
                b_vec_next = rd_key.vec;
                lerp_start = 1'b1;
                state_next = S_LERP;
            end
            S_LERP:
            begin
                if (lerp_done)
                begin
                    res_vec_next    = lerp_res;
                    res_status_next = STATUS_LERP;
                    state_next      = S_EMIT;
                end
            end
            S_FETCH:
            begin
                rd_addr    = sel_idx_reg;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                res_vec_next = rd_key.vec;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_vec_next    = res_vec_reg;
                    out_status_next = res_status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            eps_reg       <= EPSILON_RESET;
            out_valid_reg <= 1'b0;
            rd_idx_reg    <= '0;
            chk_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            rd_idx_reg    <= rd_idx_next;
            chk_vld_reg   <= chk_vld_next;
            if (epsilon_we)
            begin
                eps_reg <= epsilon_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        prev_idx_reg   <= prev_idx_next;
        cur_idx_reg    <= cur_idx_next;
        sel_idx_reg    <= sel_idx_next;
        prev_time_reg  <= prev_time_next;
        q_reg          <= q_next;
        a_vec_reg      <= a_vec_next;
        b_vec_reg      <= b_vec_next;
        res_vec_reg    <= res_vec_next;
        res_status_reg <= res_status_next;
        out_vec_reg    <= out_vec_next;
        out_status_reg <= out_status_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_x     = out_vec_reg[0];
    assign out_y     = out_vec_reg[1];
    assign out_z     = out_vec_reg[2];
    assign status    = out_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= KEYS_MAX)
        else $error("key count above track capacity");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> count_reg != '0)
        else $error("scan running on an empty track");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> alpha <= ALPHA_MAX)
        else $error("alpha out of range");

    a_lerp_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        lerp_done |-> state_reg == S_LERP)
        else $error("lerp result outside lerp wait");
`endif

endmodule

/* rtl/kvtl_key_store.sv */
// key memories: time and vector, one write port, one registered read port
module kvtl_key_store
    import kvtl_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEFAULT,
    parameter int IW       = $clog2(MAX_KEYS)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  key_t          wr_key,
    input  logic [IW-1:0] rd_addr,
    output key_t          rd_key
);

    logic [31:0] stamp_mem [MAX_KEYS];
    vec_t        vec_mem   [MAX_KEYS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stamp_mem[wr_addr] <= wr_key.stamp;
            vec_mem[wr_addr]   <= wr_key.vec;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key.stamp <= stamp_mem[rd_addr];
        rd_key.vec   <= vec_mem[rd_addr];
    end

endmodule

/* rtl/kvtl_divider.sv */
// restoring divider for alpha = (num << 16) / den, one quotient bit per cycle
module kvtl_divider
    import kvtl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        num,
    input  logic [31:0]        den,
    output div_status_t        stat,
    output logic [ALPHA_W-1:0] quot
);

    localparam logic [4:0] LAST_STEP = 5'(ALPHA_W - 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        den_reg, den_next;
    logic [ALPHA_W-1:0] bits_reg, bits_next;
    logic [ALPHA_W-1:0] quot_reg, quot_next;
    logic [32:0]        trial;
    logic               qbit;

    // num <= den, so num >> 1 is already below den and the upper quotient bits are zero
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        bits_next = bits_reg;
        quot_next = quot_reg;
        trial     = {rem_reg, bits_reg[ALPHA_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {1'b0, num[31:1]};
            den_next  = den;
            bits_next = {num[0], {(ALPHA_W-1){1'b0}}};
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            quot_next = {quot_reg[ALPHA_W-2:0], qbit};
            bits_next = {bits_reg[ALPHA_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

/* rtl/kvtl_lerp.sv */
// shared lerp pipe: subtract, multiply by alpha, shift and add, one component per cycle
module kvtl_lerp
    import kvtl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [ALPHA_W-1:0] alpha,
    input  vec_t               a_vec,
    input  vec_t               b_vec,
    output logic               done,
    output vec_t               res_vec
);

    logic               issuing_reg, issuing_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               s1_vld_reg, s2_vld_reg, done_reg;
    logic [1:0]         s1_idx_reg, s2_idx_reg;
    logic signed [32:0] s1_diff_reg;
    fix_t               s1_a_reg, s2_a_reg;
    logic signed [50:0] s2_prod_reg;
    vec_t               res_reg;

    always_comb
    begin
        issuing_next = issuing_reg;
        cnt_next     = cnt_reg;
        if (start)
        begin
            issuing_next = 1'b1;
            cnt_next     = '0;
        end
        else if (issuing_reg)
        begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == COMP_LAST)
            begin
                issuing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg <= 1'b0;
            cnt_reg     <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            issuing_reg <= issuing_next;
            cnt_reg     <= cnt_next;
            s1_vld_reg  <= issuing_reg;
            s2_vld_reg  <= s1_vld_reg;
            done_reg    <= s2_vld_reg && (s2_idx_reg == COMP_LAST);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= cnt_reg;
        s1_diff_reg <= 33'(b_vec[cnt_reg]) - 33'(a_vec[cnt_reg]);
        s1_a_reg    <= a_vec[cnt_reg];
        s2_idx_reg  <= s1_idx_reg;
        s2_prod_reg <= 51'(s1_diff_reg * $signed({1'b0, alpha}));
        s2_a_reg    <= s1_a_reg;
        // low 32 bits of floor(prod / 65536) are bits 47:16
        if (s2_vld_reg)
        begin
            res_reg[s2_idx_reg] <= s2_a_reg + $signed(s2_prod_reg[47:16]);
        end
    end

    assign done    = done_reg;
    assign res_vec = res_reg;

endmodule

/* tb/keyframe_vector_track_lerp_tb.sv */
// testbench for the keyframe vector track interpolator: directed and random tracks
`timescale 1ns / 1ps

module keyframe_vector_track_lerp_tb;
    import kvtl_pkg::*;

    localparam int          TRACK_DEPTH = MAX_KEYS_DEFAULT;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          SETTLE      = 120;
    localparam int          LONG_HOLD   = 300;
    localparam int          STALL_LIMIT = 4000;
    localparam int          ITEM_GOAL   = 1800;

    typedef struct packed {
        fix_t       x;
        fix_t       y;
        fix_t       z;
        logic [1:0] st;
    } vec_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        epsilon_we = 1'b0;
    logic [15:0] epsilon_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = CMD_CLEAR;
    logic [31:0] key_time = '0;
    fix_t        key_x = '0;
    fix_t        key_y = '0;
    fix_t        key_z = '0;
    logic [31:0] query_time = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    fix_t        out_x;
    fix_t        out_y;
    fix_t        out_z;
    logic [1:0]  status;

    // track copy used to predict query results
    logic [31:0] track_time [TRACK_DEPTH];
    fix_t        track_x [TRACK_DEPTH];
    fix_t        track_y [TRACK_DEPTH];
    fix_t        track_z [TRACK_DEPTH];
    int unsigned track_len = 0;
    logic [15:0] model_epsilon = EPSILON_RESET;
    vec_result_t expected_vectors [$];

    int unsigned error_count = 0;
    int unsigned useful_items = 0;
    int unsigned quiet_cycles = 0;
    bit          idle_in = 1'b0;
    bit          idle_out = 1'b0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned ready_gap = 0;

    keyframe_vector_track_lerp dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .epsilon_we    (epsilon_we),
        .epsilon_wdata (epsilon_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .key_time      (key_time),
        .key_x         (key_x),
        .key_y         (key_y),
        .key_z         (key_z),
        .query_time    (query_time),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_z         (out_z),
        .status        (status)
    );

    always #5 clk = ~clk;

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // a + floor((b - a) * alpha / 2^16), alpha in 0..65536
    function automatic fix_t blend_coord(fix_t a, fix_t b, logic [63:0] alpha);
        longint diff;
        longint prod;
        longint sum;
        diff = longint'(b) - longint'(a);
        prod = diff * longint'(alpha);
        sum = longint'(a) + (prod >>> 16);
        return sum[31:0];
    endfunction

    function automatic vec_result_t key_result(int unsigned idx, logic [1:0] st);
        vec_result_t r;
        r.x = track_x[idx];
        r.y = track_y[idx];
        r.z = track_z[idx];
        r.st = st;
        return r;
    endfunction

    function automatic vec_result_t lerp_lookup(logic [31:0] q);
        vec_result_t r;
        int unsigned prev;
        int unsigned i;
        logic [31:0] t;
        logic [31:0] pt;
        logic [31:0] t_gap;
        logic [63:0] span;
        logic [63:0] alpha;
        r.x = '0;
        r.y = '0;
        r.z = '0;
        r.st = STATUS_EMPTY;
        if (track_len == 0)
            return r;
        prev = 0;
        for (i = 0; i < track_len; i++)
        begin
            t = track_time[i];
            pt = track_time[prev];
            t_gap = (t >= q) ? t - q : q - t;
            if (t_gap <= {16'd0, model_epsilon})
                return key_result(i, STATUS_HIT);
            if (pt <= q && t >= q)
            begin
                span = {32'd0, t} - {32'd0, pt};
                // zero span is guarded even though an exact hit catches it first
                if (span == 0)
                    return key_result(prev, STATUS_LERP);
                alpha = (({32'd0, q} - {32'd0, pt}) << 16) / span;
                r.x = blend_coord(track_x[prev], track_x[i], alpha);
                r.y = blend_coord(track_y[prev], track_y[i], alpha);
                r.z = blend_coord(track_z[prev], track_z[i], alpha);
                r.st = STATUS_LERP;
                return r;
            end
            prev = i;
        end
        return key_result(prev, STATUS_HOLD);
    endfunction

    task automatic track_apply(input logic [1:0] cmd, input logic [31:0] kt, input fix_t kx,
                               input fix_t ky, input fix_t kz, input logic [31:0] qt);
        case (cmd)
            CMD_CLEAR:
                track_len = 0;
            CMD_APPEND:
            begin
                // appends to a full track are dropped
                if (track_len < TRACK_DEPTH)
                begin
                    track_time[track_len] = kt;
                    track_x[track_len] = kx;
                    track_y[track_len] = ky;
                    track_z[track_len] = kz;
                    track_len++;
                end
            end
            CMD_QUERY:
                expected_vectors.push_back(lerp_lookup(qt));
            default:
                ;
        endcase
        if (cmd != CMD_UNUSED)
            useful_items++;
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // called at a rising edge, returns at the edge where the transaction is taken
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] kt, input fix_t kx,
                             input fix_t ky, input fix_t kz, input logic [31:0] qt);
        int unsigned gap;
        gap = (idle_in && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        key_time   <= kt;
        key_x      <= kx;
        key_y      <= ky;
        key_z      <= kz;
        query_time <= qt;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        track_apply(cmd, kt, kx, ky, kz, qt);
    endtask

    task automatic append_key(input logic [31:0] t, input fix_t x, input fix_t y, input fix_t z);
        send_item(CMD_APPEND, t, x, y, z, $urandom());
    endtask

    task automatic query_at(input logic [31:0] q);
        send_item(CMD_QUERY, $urandom(), $urandom(), $urandom(), $urandom(), q);
    endtask

    task automatic clear_track();
        send_item(CMD_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_vectors.size() != 0)
            @(posedge clk);
    endtask

    // appends and clears give no result, so allow for one still in flight
    task automatic wait_idle();
        wait_drain();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_epsilon(input logic [15:0] value);
        wait_idle();
        epsilon_wdata <= value;
        epsilon_we    <= 1'b1;
        @(posedge clk);
        epsilon_we    <= 1'b0;
        model_epsilon = value;
    endtask

    function automatic fix_t pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_epsilon();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return EPSILON_RESET;
            3: return $urandom_range(0, 1000);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // query times aimed at keys, between keys, and anywhere
    function automatic logic [31:0] pick_query_time();
        int unsigned j;
        logic [31:0] base;
        logic [31:0] next_t;
        if (track_len == 0)
            return $urandom();
        j = $urandom_range(0, track_len - 1);
        base = track_time[j];
        case ($urandom_range(0, 6)) inside
            0: return base;
            1: return base + $urandom_range(0, 300);
            2: return base - $urandom_range(0, 300);
            3, 4:
            begin
                if (j + 1 < track_len)
                begin
                    next_t = track_time[j + 1];
                    if (next_t >= base)
                        return base + $urandom_range(0, next_t - base);
                end
                return $urandom();
            end
            5: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom();
        endcase
    endfunction

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_requests != hold_served)
        begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            out_ready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (ready_gap != 0)
        begin
            ready_gap <= ready_gap - 1;
            out_ready <= 1'b0;
        end
        else if (idle_out && $urandom_range(0, 3) == 0)
        begin
            ready_gap <= pick_gap();
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        vec_result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_vectors.size() == 0)
                flag_error($sformatf("unexpected result x=%h y=%h z=%h status=%0d",
                                     out_x, out_y, out_z, status));
            else
            begin
                want = expected_vectors.pop_front();
                if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
                    status !== want.st)
                    flag_error($sformatf({"mismatch: expected x=%h y=%h z=%h status=%0d, ",
                                          "got x=%h y=%h z=%h status=%0d"},
                                         want.x, want.y, want.z, want.st,
                                         out_x, out_y, out_z, status));
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic test_empty_track();
        query_at(32'h0);
        query_at(32'hFFFF_FFFF);
        send_item(CMD_UNUSED, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        clear_track();
        query_at($urandom());
    endtask

    task automatic test_basic_track();
        append_key(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        append_key(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        append_key(32'h0003_0000, $urandom(), $urandom(), $urandom());
        append_key(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        query_at(32'h0000_0032);
        query_at(32'h0000_8000);
        query_at(32'h0001_0042);
        query_at(32'h0001_0043);
        query_at(32'h8000_0000);
        query_at(32'hFFFF_FFFF);
        // out-of-order keys, queries before the first and past the last key
        clear_track();
        append_key(32'h0005_0000, $urandom(), $urandom(), $urandom());
        append_key(32'h0002_0000, $urandom(), $urandom(), $urandom());
        append_key(32'h0009_0000, $urandom(), $urandom(), $urandom());
        query_at(32'h0000_0100);
        query_at(32'h0003_0000);
        query_at(32'h000A_0000);
    endtask

    task automatic test_epsilon_settings();
        set_epsilon(16'd0);
        clear_track();
        append_key(32'h0001_0000, pick_coord(), pick_coord(), pick_coord());
        append_key(32'h0002_0000, pick_coord(), pick_coord(), pick_coord());
        query_at(32'h0001_0000);
        query_at(32'h0001_0001);
        set_epsilon(16'hFFFF);
        query_at(32'h0001_0001);
        query_at(32'h0001_FFFF);
        query_at(32'h0000_0001);
        set_epsilon(pick_epsilon());
        query_at(pick_query_time());
    endtask

    task automatic test_full_track();
        int unsigned k;
        idle_in = 1'b1;
        idle_out <= 1'b1;
        clear_track();
        // one append past the limit, which must be dropped
        for (k = 0; k <= TRACK_DEPTH; k++)
            append_key(k << 16, pick_coord(), pick_coord(), pick_coord());
        query_at((TRACK_DEPTH - 1) * 32'h0001_0000 + 32'h8000);
        query_at(TRACK_DEPTH * 32'h0001_0000);
        query_at(32'h000A_1234);
        query_at(32'h0);
    endtask

    task automatic test_output_stall();
        int unsigned k;
        idle_in = 1'b0;
        idle_out <= 1'b0;
        clear_track();
        for (k = 0; k < 4; k++)
            append_key($urandom_range(0, 32'h0010_0000), pick_coord(), pick_coord(),
                       pick_coord());
        hold_requests <= hold_requests + 1;
        for (k = 0; k < 16; k++)
            query_at(pick_query_time());
        // sender waits for every outstanding result before going on
        wait_drain();
        idle_in = 1'b1;
        idle_out <= 1'b1;
        for (k = 0; k < 6; k++)
            query_at(pick_query_time());
    endtask

    task automatic random_episode();
        int unsigned n_keys;
        int unsigned n_queries;
        int unsigned k;
        int unsigned pick;
        bit scrambled;
        logic [31:0] t;
        idle_in = ($urandom_range(0, 4) != 0);
        idle_out <= ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 5) == 0)
            set_epsilon(pick_epsilon());
        if ($urandom_range(0, 7) != 0)
            clear_track();
        pick = $urandom_range(0, 49);
        if (pick == 0)
            n_keys = $urandom_range(60, 70);
        else if (pick < 5)
            n_keys = $urandom_range(9, 40);
        else
            n_keys = $urandom_range(1, 8);
        scrambled = ($urandom_range(0, 9) == 0);
        t = $urandom_range(0, 1) ? $urandom_range(0, 32'h000F_FFFF) : $urandom();
        for (k = 0; k < n_keys; k++)
        begin
            if (scrambled)
                t = $urandom();
            else if (k != 0)
            begin
                case ($urandom_range(0, 3)) inside
                    0: t = t + $urandom_range(0, 200);
                    1, 2: t = t + $urandom_range(256, 32'h0004_0000);
                    default: t = t + ($urandom() >> $urandom_range(0, 16));
                endcase
            end
            append_key(t, pick_coord(), pick_coord(), pick_coord());
        end
        n_queries = $urandom_range(1, 8);
        for (k = 0; k < n_queries; k++)
        begin
            // occasional noise between queries
            case ($urandom_range(0, 19))
                0: send_item(CMD_UNUSED, $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom());
                1: append_key($urandom(), pick_coord(), pick_coord(), pick_coord());
                2: if ($urandom_range(0, 3) == 0) clear_track();
                default: ;
            endcase
            query_at(pick_query_time());
        end
    endtask

    task automatic test_random_tracks();
        while (useful_items < ITEM_GOAL)
            random_episode();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_track();
        test_basic_track();
        test_epsilon_settings();
        test_full_track();
        test_output_stall();
        test_random_tracks();
        wait_idle();
        if (expected_vectors.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_vectors.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* keyframe_vector_track_lerp.f */
rtl/kvtl_pkg.sv
rtl/kvtl_key_store.sv
rtl/kvtl_divider.sv
rtl/kvtl_lerp.sv
rtl/keyframe_vector_track_lerp.sv
tb/keyframe_vector_track_lerp_tb.sv
